@@ rtl/core/qrs_pkg.sv @@
package qrs_pkg;

    // Result classes
    typedef enum logic [1:0] {
        RC_REAL_DISTINCT = 2'd0,
        RC_REAL_EQUAL    = 2'd1,
        RC_COMPLEX       = 2'd2,
        RC_LEAD_ZERO     = 2'd3
    } t_root_class;

    localparam int COEF_W  = 16;
    localparam int VAL_W   = 40;
    localparam int NEGB_W  = 25;               // -b * 256
    localparam int DISC_W  = 35;               // b*b - 4ac
    localparam int MAG_W   = 34;               // |D|
    localparam int RAD_W   = 50;               // |D| * 2^16, even width
    localparam int ROOT_W  = RAD_W / 2;        // one root bit per sqrt stage
    localparam int SREM_W  = ROOT_W + 3;       // sqrt partial remainder
    localparam int NUM_W   = 27;               // negb +/- s
    localparam int DNUM_W  = 34;               // |num| * 128
    localparam int DREM_W  = COEF_W + 1;       // divider partial remainder

endpackage

@@ rtl/core/quadratic_root_solver.sv @@
// Quadratic root solver. A request (start high) carries a, b, c in signed
// Q8.8; one result comes back per request with a class code and two Q24.16
// values, on o_result_valid for a single cycle. busy is never raised: a
// request is taken in every cycle, and the pipeline is made of 2
// product/discriminant stages, 25 square-root stages, 1 numerator stage,
// 34 divider stages and 1 output stage, plus the input register.
// The receiver cannot stall, so each result must be captured when shown.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COEF_W-1:0]   i_coef_square,
    input  logic signed [COEF_W-1:0]   i_coef_linear,
    input  logic signed [COEF_W-1:0]   i_coef_constant,
    output logic                       o_result_valid,
    output logic [1:0]                 o_root_class,
    output logic signed [VAL_W-1:0]    o_first_value,
    output logic signed [VAL_W-1:0]    o_second_value
);

    localparam int SQ_N = ROOT_W;
    localparam int DV_N = DNUM_W;

    assign busy = 1'b0;

    // Stage 0: input capture
    logic                     r_p0_v;
    logic signed [COEF_W-1:0] r_p0_a, r_p0_b, r_p0_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
        end else begin
            r_p0_v <= start;
        end
        r_p0_a <= i_coef_square;
        r_p0_b <= i_coef_linear;
        r_p0_c <= i_coef_constant;
    end

    // Stage 1: products
    logic                     r_p1_v;
    logic signed [COEF_W-1:0] r_p1_a;
    logic signed [31:0]       r_p1_bb, r_p1_ac;
    logic signed [NEGB_W-1:0] r_p1_negb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= r_p0_v;
        end
        r_p1_a    <= r_p0_a;
        r_p1_bb   <= r_p0_b * r_p0_b;
        r_p1_ac   <= r_p0_a * r_p0_c;
        r_p1_negb <= -(NEGB_W'(r_p0_b) <<< 8);
    end

    // Stage 2: discriminant, class, |D| -> square root pipe entry
    logic signed [DISC_W-1:0] disc;
    logic [MAG_W-1:0]         disc_mag;
    t_root_class              cls;

    always_comb begin
        disc     = DISC_W'(r_p1_bb) - (DISC_W'(r_p1_ac) <<< 2);
        disc_mag = disc[DISC_W-1] ? MAG_W'(-disc) : MAG_W'(disc);
        if (r_p1_a == '0) begin
            cls = RC_LEAD_ZERO;
        end else if (disc[DISC_W-1]) begin
            cls = RC_COMPLEX;
        end else if (disc == '0) begin
            cls = RC_REAL_EQUAL;
        end else begin
            cls = RC_REAL_DISTINCT;
        end
    end

    logic                     r_sq_v    [0:SQ_N];
    logic signed [COEF_W-1:0] r_sq_a    [0:SQ_N];
    t_root_class              r_sq_cls  [0:SQ_N];
    logic signed [NEGB_W-1:0] r_sq_negb [0:SQ_N];
    logic [RAD_W-1:0]         r_sq_rad  [0:SQ_N];
    logic [SREM_W-1:0]        r_sq_rem  [0:SQ_N];
    logic [ROOT_W-1:0]        r_sq_root [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r_p1_v;
        end
        r_sq_a[0]    <= r_p1_a;
        r_sq_cls[0]  <= cls;
        r_sq_negb[0] <= r_p1_negb;
        r_sq_rad[0]  <= {disc_mag[RAD_W-17:0], 16'd0};
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    // Square root: one root bit per stage, restoring
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic [SREM_W+1:0] rem_sh, trial, diff;
        logic              ge;

        always_comb begin
            rem_sh = {r_sq_rem[k], r_sq_rad[k][RAD_W-1 -: 2]};
            trial  = (SREM_W+2)'({r_sq_root[k], 2'b01});
            ge     = (rem_sh >= trial);
            diff   = ge ? (rem_sh - trial) : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_sq_a[k+1]    <= r_sq_a[k];
            r_sq_cls[k+1]  <= r_sq_cls[k];
            r_sq_negb[k+1] <= r_sq_negb[k];
            r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
            r_sq_rem[k+1]  <= diff[SREM_W-1:0];
            r_sq_root[k+1] <= {r_sq_root[k][ROOT_W-2:0], ge};
        end
    end

    // Numerator select, magnitudes and signs -> divider entry
    logic signed [NUM_W-1:0] s_ext, nb_ext, num1, num2;
    logic [NUM_W-1:0]        mag1, mag2;

    always_comb begin
        s_ext  = NUM_W'(r_sq_root[SQ_N]);
        nb_ext = NUM_W'(r_sq_negb[SQ_N]);
        case (r_sq_cls[SQ_N])
            RC_REAL_DISTINCT: begin
                num1 = nb_ext + s_ext;
                num2 = nb_ext - s_ext;
            end
            RC_COMPLEX: begin
                num1 = nb_ext;
                num2 = s_ext;
            end
            default: begin
                num1 = nb_ext;
                num2 = nb_ext;
            end
        endcase
        mag1 = num1[NUM_W-1] ? NUM_W'(-num1) : NUM_W'(num1);
        mag2 = num2[NUM_W-1] ? NUM_W'(-num2) : NUM_W'(num2);
    end

    logic              r_dv_v    [0:DV_N];
    t_root_class       r_dv_cls  [0:DV_N];
    logic [COEF_W-1:0] r_dv_den  [0:DV_N];
    logic [1:0]        r_dv_neg  [0:DV_N];
    logic [DNUM_W-1:0] r_dv_num  [0:1][0:DV_N];
    logic [DREM_W-1:0] r_dv_rem  [0:1][0:DV_N];
    logic [DNUM_W-1:0] r_dv_quo  [0:1][0:DV_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_sq_v[SQ_N];
        end
        r_dv_cls[0]    <= r_sq_cls[SQ_N];
        r_dv_den[0]    <= r_sq_a[SQ_N][COEF_W-1] ? COEF_W'(-r_sq_a[SQ_N])
                                                 : COEF_W'(r_sq_a[SQ_N]);
        r_dv_neg[0]    <= {num2[NUM_W-1] ^ r_sq_a[SQ_N][COEF_W-1],
                           num1[NUM_W-1] ^ r_sq_a[SQ_N][COEF_W-1]};
        r_dv_num[0][0] <= DNUM_W'(mag1) << 7;
        r_dv_num[1][0] <= DNUM_W'(mag2) << 7;
        r_dv_rem[0][0] <= '0;
        r_dv_rem[1][0] <= '0;
        r_dv_quo[0][0] <= '0;
        r_dv_quo[1][0] <= '0;
    end

    // Dividers: two lanes sharing |a|, one quotient bit per stage
    for (genvar k = 0; k < DV_N; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_dv_cls[k+1] <= r_dv_cls[k];
            r_dv_den[k+1] <= r_dv_den[k];
            r_dv_neg[k+1] <= r_dv_neg[k];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DREM_W-1:0] rs;
            logic              ge;

            always_comb begin
                rs = {r_dv_rem[l][k][DREM_W-2:0], r_dv_num[l][k][DNUM_W-1]};
                ge = (rs >= DREM_W'(r_dv_den[k]));
            end

            always_ff @(posedge i_clk) begin
                r_dv_num[l][k+1] <= r_dv_num[l][k] << 1;
                r_dv_rem[l][k+1] <= ge ? (rs - DREM_W'(r_dv_den[k])) : rs;
                r_dv_quo[l][k+1] <= {r_dv_quo[l][k][DNUM_W-2:0], ge};
            end
        end
    end

    // Output: sign fix-up, zero values for a leading zero
    logic signed [VAL_W-1:0] q1, q2;

    always_comb begin
        q1 = VAL_W'(r_dv_quo[0][DV_N]);
        q2 = VAL_W'(r_dv_quo[1][DV_N]);
        if (r_dv_neg[DV_N][0]) begin
            q1 = -q1;
        end
        if (r_dv_neg[DV_N][1]) begin
            q2 = -q2;
        end
        if (r_dv_cls[DV_N] == RC_LEAD_ZERO) begin
            q1 = '0;
            q2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_dv_v[DV_N];
        end
        o_root_class   <= r_dv_cls[DV_N];
        o_first_value  <= q1;
        o_second_value <= q2;
    end

endmodule
